>>> rtl/mfsp_pkg.sv
`timescale 1ns / 1ps
package mfsp_pkg;

  localparam int VLQ_MAX_BYTES = 4;

  typedef enum logic [2:0] {
    PH_HDR    = 3'd0,
    PH_TRK    = 3'd1,
    PH_DELTA  = 3'd2,
    PH_STATUS = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_LEN    = 3'd5,
    PH_PAY    = 3'd6,
    PH_AFTER  = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_MAGIC    = 4'd1,
    ERR_HDR_LEN  = 4'd2,
    ERR_FORMAT   = 4'd3,
    ERR_TRACKS   = 4'd4,
    ERR_NO_STAT  = 4'd5,
    ERR_META_TYP = 4'd6,
    ERR_META_LEN = 4'd7,
    ERR_VLQ_LONG = 4'd8,
    ERR_OVERRUN  = 4'd9,
    ERR_TRAILING = 4'd10
  } err_t;

  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;
  localparam logic [7:0] ST_META   = 8'hFF;
  localparam logic [7:0] ST_NONE   = 8'hFF;
  localparam logic [31:0] HDR_LEN  = 32'd6;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       new_file;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [27:0] evt_delta;
    logic [7:0]  event_status;
    logic [7:0]  meta_type;
    logic [27:0] payload_len;
    logic [7:0]  data_value;
    logic        event_done;
    logic        track_done;
    logic        header_done;
    logic [47:0] header_info;
    logic [3:0]  error_code;
  } out_req_t;

  function automatic logic [7:0] hdr_magic(input logic [1:0] i);
    case (i)
      2'd0:    hdr_magic = 8'h4D;
      2'd1:    hdr_magic = 8'h54;
      2'd2:    hdr_magic = 8'h68;
      default: hdr_magic = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_magic(input logic [1:0] i);
    case (i)
      2'd0:    trk_magic = 8'h4D;
      2'd1:    trk_magic = 8'h54;
      2'd2:    trk_magic = 8'h72;
      default: trk_magic = 8'h6B;
    endcase
  endfunction

  function automatic logic [1:0] channel_len(input logic [7:0] s);
    if (s[7:4] == 4'hC || s[7:4] == 4'hD) channel_len = 2'd1;
    else if (s[7:4] != 4'hF)              channel_len = 2'd2;
    else if (s == 8'hF2)                  channel_len = 2'd2;
    else if (s == 8'hF1 || s == 8'hF3)    channel_len = 2'd1;
    else                                  channel_len = 2'd0;
  endfunction

  // {known, fixed, len}: unknown -> known=0; any length -> fixed=0
  typedef struct packed {
    logic       known;
    logic       fixed;
    logic [2:0] len;
  } meta_rule_t;

  function automatic meta_rule_t meta_rule(input logic [7:0] t);
    meta_rule_t r;
    r = '{known: 1'b1, fixed: 1'b1, len: 3'd0};
    if (t >= 8'h01 && t <= 8'h0F) r.fixed = 1'b0;
    else begin
      case (t)
        8'h00:   r.len = 3'd2;
        8'h20:   r.len = 3'd1;
        8'h21:   r.len = 3'd1;
        8'h2F:   r.len = 3'd0;
        8'h51:   r.len = 3'd3;
        8'h54:   r.len = 3'd5;
        8'h58:   r.len = 3'd4;
        8'h59:   r.len = 3'd2;
        8'h7F:   r.fixed = 1'b0;
        default: r.known = 1'b0;
      endcase
    end
    meta_rule = r;
  endfunction

endpackage

>>> rtl/midi_file_stream_parser.sv
`timescale 1ns / 1ps
// MIDI file stream parser.
// Input channel: one file byte per request (in_valid / in_stall, payload
// in_data). Set new_file on the first byte of a file to restart at the
// header magic; running status is cleared with it.
// Output channel: exactly one result request per input byte (out_valid /
// out_stall, payload out_data) carrying the byte class, event fields,
// done flags, header fields and an error code. Errors never stop parsing.
// Data path: the input byte is registered, decoded by combinational logic,
// and its result is registered. Throughput: one byte per cycle unless
// stalled; the decode of a byte depends only on the parser state left by
// the previous byte, updated in the same cycle.
// Stall: the output register and the input register form a two-deep pipe;
// input is taken whenever the input register is empty or moves on, so a
// stalled receiver backs up into in_stall after two requests.
// Reset (rst_n low, synchronous): parser returns to the header phase,
// running status cleared, both registers empty.
module midi_file_stream_parser
  import mfsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  logic     in_v_r;
  in_req_t  in_d_r;
  logic     out_v_r;
  out_req_t out_d_r;
  out_req_t res;
  logic     step;

  assign step     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step;

  mfsp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (in_d_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (step) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_d_r <= in_data;
    if (step) out_d_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

>>> rtl/mfsp_core.sv
`timescale 1ns / 1ps
module mfsp_core
  import mfsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_req_t  req,
  output out_req_t res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [47:0] hshift_r, hshift_nxt;
  logic [15:0] tleft_r, tleft_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] ccnt_r, ccnt_nxt;
  logic [27:0] vacc_r, vacc_nxt;
  logic [2:0]  vbytes_r, vbytes_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [7:0]  cstat_r, cstat_nxt;
  logic [7:0]  cmeta_r, cmeta_nxt;
  logic [27:0] pleft_r, pleft_nxt;
  logic [27:0] edelta_r, edelta_nxt;
  logic [27:0] elen_r, elen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      fidx_r   <= '0;
      hshift_r <= '0;
      tleft_r  <= '0;
      clen_r   <= '0;
      ccnt_r   <= '0;
      vacc_r   <= '0;
      vbytes_r <= '0;
      rstat_r  <= ST_NONE;
      cstat_r  <= '0;
      cmeta_r  <= '0;
      pleft_r  <= '0;
      edelta_r <= '0;
      elen_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fidx_r   <= fidx_nxt;
      hshift_r <= hshift_nxt;
      tleft_r  <= tleft_nxt;
      clen_r   <= clen_nxt;
      ccnt_r   <= ccnt_nxt;
      vacc_r   <= vacc_nxt;
      vbytes_r <= vbytes_nxt;
      rstat_r  <= rstat_nxt;
      cstat_r  <= cstat_nxt;
      cmeta_r  <= cmeta_nxt;
      pleft_r  <= pleft_nxt;
      edelta_r <= edelta_nxt;
      elen_r   <= elen_nxt;
    end
  end

  always_comb begin
    logic [7:0]  b;
    phase_t      ph;
    logic [3:0]  fi;
    logic [47:0] hs;
    logic [15:0] tl;
    logic [31:0] cl, cc;
    logic [27:0] va, pl, ed, el;
    logic [2:0]  vb;
    logic [7:0]  rs, cs, cm;
    logic [2:0]  cls;
    logic [7:0]  dv;
    err_t        err;
    logic        evd, trd, hdd, vdone;
    logic [47:0] hinfo;
    logic [1:0]  chl;
    meta_rule_t  mr;
    logic [15:0] fmt, trk;
    logic [15:0] tl_dec;

    b = req.file_byte;
    if (req.new_file) begin
      ph = PH_HDR; fi = '0; hs = '0; tl = '0; cl = '0; cc = '0;
      va = '0; vb = '0; rs = ST_NONE; cs = '0; cm = '0; pl = '0; ed = '0; el = '0;
    end else begin
      ph = phase_r; fi = fidx_r; hs = hshift_r; tl = tleft_r; cl = clen_r; cc = ccnt_r;
      va = vacc_r; vb = vbytes_r; rs = rstat_r; cs = cstat_r; cm = cmeta_r;
      pl = pleft_r; ed = edelta_r; el = elen_r;
    end

    cls = ph;
    dv = '0; err = ERR_NONE; evd = 1'b0; trd = 1'b0; hdd = 1'b0; hinfo = '0;
    vdone = 1'b0;
    fmt = hs[31:16]; trk = hs[15:0];
    mr = meta_rule(cm);
    chl = '0;

    if (ph >= PH_DELTA && ph <= PH_PAY && cc != 32'hFFFF_FFFF) cc = cc + 32'd1;

    // shared VLQ step for delta and length phases
    if (ph == PH_DELTA || ph == PH_LEN) begin
      va = {va[20:0], b[6:0]};
      vb = vb + 3'd1;
      if (!b[7]) vdone = 1'b1;
      else if (vb >= 3'(VLQ_MAX_BYTES)) begin
        vdone = 1'b1;
        err = ERR_VLQ_LONG;
      end
    end

    case (ph)
      PH_HDR: begin
        if (fi < 4'd4) begin
          if (b != hdr_magic(fi[1:0])) err = ERR_MAGIC;
        end else if (fi < 4'd8) begin
          cl = {cl[23:0], b};
          if (fi == 4'd7 && cl != HDR_LEN) err = ERR_HDR_LEN;
        end else begin
          hs = {hs[39:0], b};
          fmt = hs[31:16]; trk = hs[15:0];
          if (fi == 4'd9 && hs[15:0] > 16'd2) err = ERR_FORMAT;
          if (fi == 4'd11) begin
            tl = trk;
            if ((fmt == 16'd0 && trk != 16'd1) || trk == 16'd0) err = ERR_TRACKS;
          end
        end
        if (fi >= 4'd13) begin
          hdd = 1'b1;
          hinfo = hs;
          fi = '0;
          ph = (tl != 16'd0) ? PH_TRK : PH_AFTER;
        end else begin
          fi = fi + 4'd1;
        end
      end
      PH_TRK: begin
        if (fi[2:0] < 3'd4) begin
          if (b != trk_magic(fi[1:0])) err = ERR_MAGIC;
          if (fi[2:0] == 3'd0) cl = '0;
        end else begin
          cl = {cl[23:0], b};
        end
        if (fi[2:0] == 3'd7) begin
          fi = '0; cc = '0;
          ph = PH_DELTA; va = '0; vb = '0; cs = '0; cm = '0; pl = '0; ed = '0; el = '0;
        end else begin
          fi = {1'b0, fi[2:0] + 3'd1};
        end
      end
      PH_DELTA: begin
        if (vdone) begin
          ed = va;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == ST_SYSEX || b == ST_ESCAPE) begin
          cs = b; va = '0; vb = '0; ph = PH_LEN;
        end else if (b == ST_META) begin
          cs = b; ph = PH_MTYPE;
        end else if (b[7]) begin
          rs = b; cs = b;
          chl = channel_len(b);
          el = 28'(chl); pl = 28'(chl);
          if (chl == 2'd0) evd = 1'b1;
          else ph = PH_PAY;
        end else begin
          cls = PH_PAY;
          dv = b;
          if (rs == ST_NONE) begin
            err = ERR_NO_STAT; evd = 1'b1;
          end else begin
            cs = rs;
            chl = channel_len(rs);
            el = 28'(chl);
            if (chl <= 2'd1) evd = 1'b1;
            else begin
              pl = 28'(chl - 2'd1); ph = PH_PAY;
            end
          end
        end
      end
      PH_MTYPE: begin
        cm = b;
        mr = meta_rule(b);
        if (!mr.known) err = ERR_META_TYP;
        va = '0; vb = '0; ph = PH_LEN;
      end
      PH_LEN: begin
        if (vdone) begin
          el = va;
          if (cs == ST_META && mr.known && mr.fixed && 28'(mr.len) != el &&
              err == ERR_NONE) err = ERR_META_LEN;
          pl = el;
          if (el == '0) evd = 1'b1;
          else ph = PH_PAY;
        end
      end
      PH_PAY: begin
        dv = b;
        if (pl != '0) pl = pl - 28'd1;
        if (pl == '0) evd = 1'b1;
      end
      default: err = ERR_TRAILING;
    endcase

    res.byte_class = cls;
    if (cls >= PH_DELTA && cls <= PH_PAY) begin
      res.evt_delta = ed; res.event_status = cs; res.meta_type = cm; res.payload_len = el;
    end else begin
      res.evt_delta = '0; res.event_status = '0; res.meta_type = '0; res.payload_len = '0;
    end

    tl_dec = tl - 16'd1;
    if (evd) begin
      if (cc > cl && err == ERR_NONE) err = ERR_OVERRUN;
      if (cc >= cl) begin
        trd = 1'b1;
        tl = tl_dec;
        fi = '0;
        ph = (tl_dec != 16'd0) ? PH_TRK : PH_AFTER;
      end else begin
        ph = PH_DELTA; va = '0; vb = '0; cs = '0; cm = '0; pl = '0; ed = '0; el = '0;
      end
    end

    res.data_value  = dv;
    res.event_done  = evd;
    res.track_done  = trd;
    res.header_done = hdd;
    res.header_info = hinfo;
    res.error_code  = err;

    phase_nxt = ph; fidx_nxt = fi; hshift_nxt = hs; tleft_nxt = tl; clen_nxt = cl;
    ccnt_nxt = cc; vacc_nxt = va; vbytes_nxt = vb; rstat_nxt = rs; cstat_nxt = cs;
    cmeta_nxt = cm; pleft_nxt = pl; edelta_nxt = ed; elen_nxt = el;
  end

endmodule
